@@ src/abq_pkg.sv @@
// Shared widths, register indexes and reset values for the analog button qualifier.
package abq_pkg;

   localparam int SAMPLE_WIDTH    = 10;
   localparam int TIME_WIDTH      = 32;
   localparam int DURATION_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PRESS_THRESHOLD   = 2'd0,
      CSR_RELEASE_THRESHOLD = 2'd1,
      CSR_LOCKOUT_MS        = 2'd2,
      CSR_LONG_PRESS_MS     = 2'd3
   } csr_index_type;

   // Register values after reset
   localparam logic [SAMPLE_WIDTH-1:0]   PRESS_THRESHOLD_RESET   = 10'd300;
   localparam logic [SAMPLE_WIDTH-1:0]   RELEASE_THRESHOLD_RESET = 10'd400;
   localparam logic [DURATION_WIDTH-1:0] LOCKOUT_MS_RESET        = 16'd30;
   localparam logic [DURATION_WIDTH-1:0] LONG_PRESS_MS_RESET     = 16'd1000;

endpackage

@@ src/analog_button_qualifier_core.sv @@
// Analog button qualifier: hysteresis, debounce lockout and long-press detection.
//
// One item a cycle while rsp is not stalled: each req item (a 10-bit sample and
// a 32-bit millisecond time) yields exactly one rsp item. An item is captured in
// an input register; once the result register is empty or being taken, one pass
// of compare and add/subtract logic updates the button state and loads the
// result register, so back-to-back items run at full rate. The rate is set by
// the state update loop (raw level, debounced state, lockout
// end, press start). The result register holds a finished item while the next
// one is taken in; req_ready drops only when both registers are full and rsp is
// stalled. Time comparisons wrap at 32 bits; the lockout test is a plain
// unsigned compare of now_ms against the stored lockout end. Configuration
// writes take effect at once and are meant to be made while the block is idle.
module analog_button_qualifier_core
   import abq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_WIDTH-1:0]    req_sample,
   input  logic [TIME_WIDTH-1:0]      req_now_ms,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_pressed,
   output logic                       rsp_press_pulse,
   output logic                       rsp_release_pulse,
   output logic                       rsp_long_pulse,

   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Configuration registers
   logic [SAMPLE_WIDTH-1:0]   press_threshold_ff;
   logic [SAMPLE_WIDTH-1:0]   release_threshold_ff;
   logic [DURATION_WIDTH-1:0] lockout_ms_ff;
   logic [DURATION_WIDTH-1:0] long_press_ms_ff;

   // Input stage
   logic                      in_valid_ff;
   logic [SAMPLE_WIDTH-1:0]   in_sample_ff;
   logic [TIME_WIDTH-1:0]     in_now_ff;

   // Button state
   logic                      raw_last_ff,      raw_last_in;
   logic                      pressed_state_ff, pressed_state_in;
   logic [TIME_WIDTH-1:0]     lockout_end_ff,   lockout_end_in;
   logic [TIME_WIDTH-1:0]     press_start_ff,   press_start_in;
   logic                      long_done_ff,     long_done_in;

   // Result stage
   logic                      out_valid_ff;
   logic                      out_pressed_ff;
   logic                      out_press_pulse_ff,   press_pulse_in;
   logic                      out_release_pulse_ff, release_pulse_in;
   logic                      out_long_pulse_ff,    long_pulse_in;

   logic                      out_load;
   logic                      in_load;
   logic                      raw;
   logic                      locked;
   logic [TIME_WIDTH-1:0]     lock_sum;
   logic [TIME_WIDTH-1:0]     held_time;

   // Handshake: result register frees when empty or taken, input stage follows
   assign out_load  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || out_load;
   assign in_load   = req_valid && req_ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         press_threshold_ff   <= PRESS_THRESHOLD_RESET;
         release_threshold_ff <= RELEASE_THRESHOLD_RESET;
         lockout_ms_ff        <= LOCKOUT_MS_RESET;
         long_press_ms_ff     <= LONG_PRESS_MS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PRESS_THRESHOLD:   press_threshold_ff   <= csr_wdata[SAMPLE_WIDTH-1:0];
            CSR_RELEASE_THRESHOLD: release_threshold_ff <= csr_wdata[SAMPLE_WIDTH-1:0];
            CSR_LOCKOUT_MS:        lockout_ms_ff        <= csr_wdata[DURATION_WIDTH-1:0];
            CSR_LONG_PRESS_MS:     long_press_ms_ff     <= csr_wdata[DURATION_WIDTH-1:0];
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_sample_ff <= req_sample;
         in_now_ff    <= req_now_ms;
      end
   end

   // Hysteresis, lockout and edge/long-press decisions for the item in the input stage
   always_comb begin
      raw = raw_last_ff ? (in_sample_ff < release_threshold_ff)
                        : (in_sample_ff < press_threshold_ff);
      locked   = in_now_ff < lockout_end_ff;
      lock_sum = in_now_ff + {{(TIME_WIDTH-DURATION_WIDTH){1'b0}}, lockout_ms_ff};

      raw_last_in      = raw;
      pressed_state_in = pressed_state_ff;
      lockout_end_in   = lockout_end_ff;
      press_start_in   = press_start_ff;
      long_done_in     = long_done_ff;
      press_pulse_in   = 1'b0;
      release_pulse_in = 1'b0;
      long_pulse_in    = 1'b0;

      if (!locked) begin
         if (raw && !pressed_state_ff) begin
            pressed_state_in = 1'b1;
            press_pulse_in   = 1'b1;
            press_start_in   = in_now_ff;
            long_done_in     = 1'b0;
            lockout_end_in   = lock_sum;
         end else if (!raw && pressed_state_ff) begin
            pressed_state_in = 1'b0;
            release_pulse_in = 1'b1;
            lockout_end_in   = lock_sum;
         end
      end

      // held time is zero on the tick of the press itself
      held_time = in_now_ff - press_start_in;
      if (!locked && pressed_state_in && !long_done_in &&
          held_time >= {{(TIME_WIDTH-DURATION_WIDTH){1'b0}}, long_press_ms_ff}) begin
         long_pulse_in = 1'b1;
         long_done_in  = 1'b1;
      end
   end

   // State update, one item per load
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_last_ff      <= 1'b0;
         pressed_state_ff <= 1'b0;
         lockout_end_ff   <= '0;
         press_start_ff   <= '0;
         long_done_ff     <= 1'b0;
      end else if (out_load) begin
         raw_last_ff      <= raw_last_in;
         pressed_state_ff <= pressed_state_in;
         lockout_end_ff   <= lockout_end_in;
         press_start_ff   <= press_start_in;
         long_done_ff     <= long_done_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pressed_ff       <= pressed_state_in;
         out_press_pulse_ff   <= press_pulse_in;
         out_release_pulse_ff <= release_pulse_in;
         out_long_pulse_ff    <= long_pulse_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pressed       = out_pressed_ff;
   assign rsp_press_pulse   = out_press_pulse_ff;
   assign rsp_release_pulse = out_release_pulse_ff;
   assign rsp_long_pulse    = out_long_pulse_ff;

endmodule

@@ src/abq_checker.sv @@
// Port-level checks for the analog button qualifier, bound to analog_button_qualifier_core.
module abq_checker
   import abq_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_pressed,
   input logic                       rsp_press_pulse,
   input logic                       rsp_release_pulse,
   input logic                       rsp_long_pulse
);

   logic last_pressed_ff;

   // Pressed level of the last delivered item
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pressed_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         last_pressed_ff <= rsp_pressed;
      end
   end

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pressed) &&
         $stable(rsp_press_pulse) && $stable(rsp_release_pulse) && $stable(rsp_long_pulse))
      else $error("rsp item changed while stalled");

   // Pressed level changes only with the matching edge pulse
   a_press_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_press_pulse || (rsp_pressed && !last_pressed_ff))
      |-> rsp_press_pulse && rsp_pressed && !last_pressed_ff)
      else $error("press edge and pressed level disagree");

   a_release_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_release_pulse || (!rsp_pressed && last_pressed_ff))
      |-> rsp_release_pulse && !rsp_pressed && last_pressed_ff)
      else $error("release edge and pressed level disagree");

   // Long press only while pressed
   a_long_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_long_pulse |-> rsp_pressed)
      else $error("long pulse while released");

   // Nothing is offered in the first cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind analog_button_qualifier_core abq_checker u_abq_checker (.*);
